// ----- rtl/swc3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swc3_pkg;

    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_ROW_W = 3 * COEF_W;
    localparam int PROD_W     = PIX_W + COEF_W;
    localparam int ROW_SUM_W  = PROD_W + 2;
    localparam int SUM_W      = PROD_W + 4;
    localparam int OUT_W      = 32;
    localparam int WIDTH_W    = 11;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_ROW_W;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 11'd3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SHIFT  = 3'd4;

    localparam logic [1:0] ROW_FULL = 2'd2;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_value;
        logic                    frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered_value;
        logic                    window_valid;
        logic                    saturated;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/sliding_window_convolution_3x3_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   pixel_in_t (pixel_value, frame_start)
// m_        out        m_valid / m_ready   result_t (filtered_value, window_valid, saturated)
// cfg_      in         cfg_we              cfg_addr, cfg_wdata
//
// One item is taken per clock unless m_ready holds the pipeline back.
// The line stores are read when an item is taken and written when it leaves stage one,
// with a bypass when two items in a row use the same column.
// Reset (aresetn low, synchronous) empties the pipeline, clears the counters and window,
// and loads the register defaults; the line stores keep no reset value.
// Each stage holds its item only while the stage after it is full and stalled.

module sliding_window_convolution_3x3_top
    import swc3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output      logic                   s_ready,
    input  wire pixel_in_t              s_data,

    output      logic                   m_valid,
    input  wire logic                   m_ready,
    output      result_t                m_data,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    // Configuration registers.
    logic [WIDTH_W-1:0]    width_reg;
    logic [COEF_ROW_W-1:0] coef_reg [0:2];
    logic [SHIFT_W-1:0]    shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_RESET;
            coef_reg[0] <= '0;
            coef_reg[1] <= '0;
            coef_reg[2] <= '0;
            shift_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH: width_reg   <= cfg_wdata[WIDTH_W-1:0];
                REG_COEF_TOP:    coef_reg[0] <= cfg_wdata[COEF_ROW_W-1:0];
                REG_COEF_MID:    coef_reg[1] <= cfg_wdata[COEF_ROW_W-1:0];
                REG_COEF_BOT:    coef_reg[2] <= cfg_wdata[COEF_ROW_W-1:0];
                REG_COEF_SHIFT:  shift_reg   <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers.
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                    s5_valid_reg, m_valid_reg;
    logic                    s1_ok_reg, s2_ok_reg, s3_ok_reg, s4_ok_reg, s5_ok_reg;
    logic [CW-1:0]           s1_addr_reg;
    logic [PIX_W-1:0]        s1_pix_reg;
    logic [PIX_W-1:0]        rd_older_reg, rd_newer_reg;
    logic                    fwd_reg;
    logic [PIX_W-1:0]        fwd_older_reg, fwd_newer_reg;
    logic [PIX_W-1:0]        win_reg [0:8];
    logic signed [PROD_W-1:0]    prod_reg [0:8];
    logic signed [ROW_SUM_W-1:0] row_sum_reg [0:2];
    logic signed [SUM_W-1:0]     total_reg;
    result_t                 m_data_reg;

    logic [CW-1:0]           col_reg, col_next;
    logic [1:0]              row_reg, row_next;

    // Stage movement.
    logic m_free, mv1, mv2, mv3, mv4, mv5;
    logic s1_free, s2_free, s3_free, s4_free, s5_free, acc;

    always_comb begin
        m_free  = !m_valid_reg || m_ready;
        mv5     = s5_valid_reg && m_free;
        s5_free = !s5_valid_reg || mv5;
        mv4     = s4_valid_reg && s5_free;
        s4_free = !s4_valid_reg || mv4;
        mv3     = s3_valid_reg && s4_free;
        s3_free = !s3_valid_reg || mv3;
        mv2     = s2_valid_reg && s3_free;
        s2_free = !s2_valid_reg || mv2;
        mv1     = s1_valid_reg && s2_free;
        s1_free = !s1_valid_reg || mv1;
    end

    assign s_ready = s1_free;
    assign acc     = s_valid && s1_free;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Column and row counting.
    logic [EW-1:0] eff_width, width_ext, col_inc;
    logic [CW-1:0] col_base;
    logic [1:0]    row_base;
    logic          win_ok, wrap;

    always_comb begin
        width_ext = EW'(width_reg);
        if (width_ext < EW'(WIDTH_MIN)) begin
            eff_width = EW'(WIDTH_MIN);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        col_base = s_data.frame_start ? '0 : col_reg;
        row_base = s_data.frame_start ? '0 : row_reg;
        win_ok   = (row_base == ROW_FULL) && (col_base >= CW'(2));
        col_inc  = EW'(col_base) + EW'(1);
        wrap     = col_inc >= eff_width;
        col_next = wrap ? '0 : col_inc[CW-1:0];
        row_next = (wrap && row_base != ROW_FULL) ? row_base + 2'd1 : row_base;
    end

    // Line stores with bypass from the write in the first stage.
    logic [PIX_W-1:0] older_mem [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] newer_mem [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] top_eff, mid_eff;

    assign top_eff = fwd_reg ? fwd_older_reg : rd_older_reg;
    assign mid_eff = fwd_reg ? fwd_newer_reg : rd_newer_reg;

    always_ff @(posedge aclk) begin
        if (mv1) begin
            older_mem[s1_addr_reg] <= mid_eff;
        end
        if (acc) begin
            rd_older_reg <= older_mem[col_base];
        end
    end

    always_ff @(posedge aclk) begin
        if (mv1) begin
            newer_mem[s1_addr_reg] <= s1_pix_reg;
        end
        if (acc) begin
            rd_newer_reg <= newer_mem[col_base];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (acc) begin
                col_reg <= col_next;
                row_reg <= row_next;
                fwd_reg <= mv1 && (s1_addr_reg == col_base);
            end else if (mv1) begin
                fwd_reg <= 1'b0;
            end
            if (acc) begin
                s1_valid_reg <= 1'b1;
            end else if (mv1) begin
                s1_valid_reg <= 1'b0;
            end
            if (mv1) begin
                s2_valid_reg <= 1'b1;
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= top_eff;
                win_reg[5] <= mid_eff;
                win_reg[8] <= s1_pix_reg;
            end else if (mv2) begin
                s2_valid_reg <= 1'b0;
            end
            if (mv2) begin
                s3_valid_reg <= 1'b1;
            end else if (mv3) begin
                s3_valid_reg <= 1'b0;
            end
            if (mv3) begin
                s4_valid_reg <= 1'b1;
            end else if (mv4) begin
                s4_valid_reg <= 1'b0;
            end
            if (mv4) begin
                s5_valid_reg <= 1'b1;
            end else if (mv5) begin
                s5_valid_reg <= 1'b0;
            end
            if (mv5) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    logic signed [COEF_W-1:0] coef [0:8];
    logic signed [SUM_W-1:0]  shifted;
    logic                     overflow;
    result_t                  result_next;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r*3+c] = coef_reg[r][c*COEF_W +: COEF_W];
            end
        end
        shifted  = total_reg >>> shift_reg;
        overflow = !((&shifted[SUM_W-1:OUT_W-1]) || !(|shifted[SUM_W-1:OUT_W-1]));
        result_next.window_valid = s5_ok_reg;
        if (!s5_ok_reg) begin
            result_next.filtered_value = '0;
            result_next.saturated      = 1'b0;
        end else if (overflow) begin
            result_next.filtered_value = shifted[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                          : {1'b0, {(OUT_W-1){1'b1}}};
            result_next.saturated      = 1'b1;
        end else begin
            result_next.filtered_value = shifted[OUT_W-1:0];
            result_next.saturated      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_addr_reg   <= col_base;
            s1_pix_reg    <= s_data.pixel_value;
            s1_ok_reg     <= win_ok;
            fwd_older_reg <= mid_eff;
            fwd_newer_reg <= s1_pix_reg;
        end
        if (mv1) begin
            s2_ok_reg <= s1_ok_reg;
        end
        if (mv2) begin
            s3_ok_reg <= s2_ok_reg;
            for (int i = 0; i < 9; i++) begin
                prod_reg[i] <= $signed(win_reg[i]) * coef[i];
            end
        end
        if (mv3) begin
            s4_ok_reg <= s3_ok_reg;
            for (int r = 0; r < 3; r++) begin
                row_sum_reg[r] <= ROW_SUM_W'(prod_reg[r*3]) + ROW_SUM_W'(prod_reg[r*3+1])
                                + ROW_SUM_W'(prod_reg[r*3+2]);
            end
        end
        if (mv4) begin
            s5_ok_reg <= s4_ok_reg;
            total_reg <= SUM_W'(row_sum_reg[0]) + SUM_W'(row_sum_reg[1])
                       + SUM_W'(row_sum_reg[2]);
        end
        if (mv5) begin
            m_data_reg <= result_next;
        end
    end

    ap_fwd_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> s1_valid_reg)
        else $error("line store bypass set without an item in the read stage");

    ap_border_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.window_valid)
            |-> (m_data_reg.filtered_value == '0) && !m_data_reg.saturated)
        else $error("border result carries a nonzero value or saturation");

    ap_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg != 2'd3)
        else $error("row count passed its saturation point");

    ap_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s1_valid_reg) |-> mv1)
        else $error("item taken while the read stage was held");

    ap_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(col_reg) < EW'(MAX_WIDTH))
        else $error("column count beyond the line store depth");

endmodule

`default_nettype wire
